>>> rtl/core/rgbcg_pkg.sv
package rgbcg_pkg;

  // Register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_GRADE_MODE = 3'd0,
    REG_RED_GAIN   = 3'd1,
    REG_RED_BIAS   = 3'd2,
    REG_GREEN_GAIN = 3'd3,
    REG_GREEN_BIAS = 3'd4,
    REG_BLUE_GAIN  = 3'd5,
    REG_BLUE_BIAS  = 3'd6
  } reg_idx_e;

  // Grade modes; code three behaves as bypass
  typedef enum logic [1:0] {
    MODE_BYPASS = 2'd0,
    MODE_CURVE  = 2'd1,
    MODE_SEPIA  = 2'd2
  } grade_mode_e;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned GAIN_W = 11;
  localparam int unsigned BIAS_W = 9;
  localparam int unsigned NUM_W  = 20;  // dividend before /1000, max 522485
  localparam int unsigned QUO_W  = 10;  // quotient after /1000, max 522
  localparam int unsigned SUM_W  = 12;  // signed sums ahead of saturation

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1000);

  // n/1000 == (n * RECIP_M) >> RECIP_SHIFT for every n below 2^NUM_W
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(1073742);
  localparam int unsigned PROD_W = NUM_W + RECIP_W;

  localparam logic [NUM_W-1:0] HALF_UNIT = NUM_W'(500);

  // Sepia weights in thousandths
  localparam logic [NUM_W-1:0] W_RR = NUM_W'(393);
  localparam logic [NUM_W-1:0] W_RG = NUM_W'(769);
  localparam logic [NUM_W-1:0] W_RB = NUM_W'(189);
  localparam logic [NUM_W-1:0] W_GR = NUM_W'(349);
  localparam logic [NUM_W-1:0] W_GG = NUM_W'(686);
  localparam logic [NUM_W-1:0] W_GB = NUM_W'(168);
  localparam logic [NUM_W-1:0] W_BR = NUM_W'(272);
  localparam logic [NUM_W-1:0] W_BG = NUM_W'(534);
  localparam logic [NUM_W-1:0] W_BB = NUM_W'(131);

endpackage

>>> rtl/core/rgb_color_grade_gain_bias_sepia_core.sv
// Channel   Handshake                   Payload
// --------  --------------------------  ------------------------------------------
// in        in_valid_i / in_ready_o     red_in_i green_in_i blue_in_i alpha_in_i
//                                       frame_end_in_i
// out       out_valid_o / out_ready_i   red_out_o green_out_o blue_out_o alpha_out_o
//                                       frame_end_out_o
// cfg       APB psel_i/penable_i        paddr_i pwdata_i prdata_o, pready_o tied high
//
// One word per cycle sustained while out_ready_i is held high.
// The four register stages are: input, multiply by gain or sepia weight, divide by
// 1000 through a reciprocal multiply, add bias and saturate into the output register.
// Reset clears the stage valid bits and loads the register defaults (gains 1000).
// Stall: each stage holds while its successor is full and blocked, so a bubble
// anywhere is squeezed out; in_ready_o drops only once all four stages hold a word.
module rgb_color_grade_gain_bias_sepia_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel in
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rgbcg_pkg::PIX_W-1:0]   red_in_i,
  input  logic [rgbcg_pkg::PIX_W-1:0]   green_in_i,
  input  logic [rgbcg_pkg::PIX_W-1:0]   blue_in_i,
  input  logic [rgbcg_pkg::PIX_W-1:0]   alpha_in_i,
  input  logic                          frame_end_in_i,
  // pixel out
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rgbcg_pkg::PIX_W-1:0]   red_out_o,
  output logic [rgbcg_pkg::PIX_W-1:0]   green_out_o,
  output logic [rgbcg_pkg::PIX_W-1:0]   blue_out_o,
  output logic [rgbcg_pkg::PIX_W-1:0]   alpha_out_o,
  output logic                          frame_end_out_o,
  // register port
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [4:0]                    paddr_i,
  input  logic [31:0]                   pwdata_i,
  output logic [31:0]                   prdata_o,
  output logic                          pready_o
);
  import rgbcg_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]        mode_q;
  logic [GAIN_W-1:0] gain_q [3];
  logic [BIAS_W-1:0] bias_q [3];
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign cfg_idx  = reg_idx_e'(paddr_i[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BYPASS;
      gain_q[0] <= GAIN_RESET;
      gain_q[1] <= GAIN_RESET;
      gain_q[2] <= GAIN_RESET;
      bias_q[0] <= '0;
      bias_q[1] <= '0;
      bias_q[2] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRADE_MODE: mode_q    <= pwdata_i[1:0];
        REG_RED_GAIN:   gain_q[0] <= pwdata_i[GAIN_W-1:0];
        REG_RED_BIAS:   bias_q[0] <= pwdata_i[BIAS_W-1:0];
        REG_GREEN_GAIN: gain_q[1] <= pwdata_i[GAIN_W-1:0];
        REG_GREEN_BIAS: bias_q[1] <= pwdata_i[BIAS_W-1:0];
        REG_BLUE_GAIN:  gain_q[2] <= pwdata_i[GAIN_W-1:0];
        REG_BLUE_BIAS:  bias_q[2] <= pwdata_i[BIAS_W-1:0];
        default: ;  // unmapped word, write dropped
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (cfg_idx)
      REG_GRADE_MODE: prdata_o = 32'(mode_q);
      REG_RED_GAIN:   prdata_o = 32'(gain_q[0]);
      REG_RED_BIAS:   prdata_o = 32'(bias_q[0]);
      REG_GREEN_GAIN: prdata_o = 32'(gain_q[1]);
      REG_GREEN_BIAS: prdata_o = 32'(bias_q[1]);
      REG_BLUE_GAIN:  prdata_o = 32'(gain_q[2]);
      REG_BLUE_BIAS:  prdata_o = 32'(bias_q[2]);
      default:        prdata_o = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its contents move on
  // ---------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic s1_en, s2_en, s3_en, out_en;

  assign out_en = ~out_vld_q | out_ready_i;
  assign s3_en  = ~s3_vld_q  | out_en;
  assign s2_en  = ~s2_vld_q  | s3_en;
  assign s1_en  = ~s1_vld_q  | s2_en;

  assign in_ready_o  = s1_en;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_en)  s1_vld_q  <= in_valid_i;
      if (s2_en)  s2_vld_q  <= s1_vld_q;
      if (s3_en)  s3_vld_q  <= s2_vld_q;
      if (out_en) out_vld_q <= s3_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] s1_pix_q [3];
  logic [PIX_W-1:0] s1_alpha_q;
  logic             s1_fe_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_pix_q[0] <= red_in_i;
      s1_pix_q[1] <= green_in_i;
      s1_pix_q[2] <= blue_in_i;
      s1_alpha_q  <= alpha_in_i;
      s1_fe_q     <= frame_end_in_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: dividends. Slots 0..2 carry the rounded curve product per channel
  // or the three rounded sepia red terms; slots 3, 4 carry sepia green/blue.
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] s2_num_d [5];
  logic [NUM_W-1:0] s2_num_q [5];
  logic [PIX_W-1:0] s2_pix_q [3];
  logic [PIX_W-1:0] s2_alpha_q;
  logic             s2_fe_q;
  logic [NUM_W-1:0] r_w, g_w, b_w;

  assign r_w = NUM_W'(s1_pix_q[0]);
  assign g_w = NUM_W'(s1_pix_q[1]);
  assign b_w = NUM_W'(s1_pix_q[2]);

  always_comb begin
    if (mode_q == MODE_CURVE) begin
      for (int c = 0; c < 3; c++) begin
        s2_num_d[c] = NUM_W'(gain_q[c]) * NUM_W'(s1_pix_q[c]) + HALF_UNIT;
      end
    end else begin
      s2_num_d[0] = r_w * W_RR + HALF_UNIT;
      s2_num_d[1] = g_w * W_RG + HALF_UNIT;
      s2_num_d[2] = b_w * W_RB + HALF_UNIT;
    end
    s2_num_d[3] = r_w * W_GR + g_w * W_GG + b_w * W_GB;
    s2_num_d[4] = r_w * W_BR + g_w * W_BG + b_w * W_BB;
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_num_q   <= s2_num_d;
      s2_pix_q   <= s1_pix_q;
      s2_alpha_q <= s1_alpha_q;
      s2_fe_q    <= s1_fe_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by 1000 via reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] s3_prod [5];
  logic [QUO_W-1:0]  s3_quo_q [5];
  logic [PIX_W-1:0]  s3_pix_q [3];
  logic [PIX_W-1:0]  s3_alpha_q;
  logic              s3_fe_q;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      s3_prod[k] = PROD_W'(s2_num_q[k]) * PROD_W'(RECIP_M);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      for (int k = 0; k < 5; k++) begin
        s3_quo_q[k] <= s3_prod[k][RECIP_SHIFT +: QUO_W];
      end
      s3_pix_q   <= s2_pix_q;
      s3_alpha_q <= s2_alpha_q;
      s3_fe_q    <= s2_fe_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: add bias / sum red terms, clamp to 0..255
  // ---------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] sat_pix(input logic signed [SUM_W-1:0] v);
    if (v < 0)                               sat_pix = '0;
    else if (v > $signed(SUM_W'(255)))       sat_pix = '1;
    else                                     sat_pix = v[PIX_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] curve_sum [3];
  logic signed [SUM_W-1:0] sepia_red;
  logic [PIX_W-1:0]        pix_d [3];
  logic [PIX_W-1:0]        pix_q [3];
  logic [PIX_W-1:0]        alpha_q;
  logic                    fe_q;

  always_comb begin
    // (t+500)/1000 == round(gain*x/1000) + bias, since 1000*bias is exact
    for (int c = 0; c < 3; c++) begin
      curve_sum[c] = $signed(SUM_W'(s3_quo_q[c]))
                   + SUM_W'($signed(bias_q[c]));
    end
    sepia_red = $signed(SUM_W'(s3_quo_q[0]) + SUM_W'(s3_quo_q[1])
                        + SUM_W'(s3_quo_q[2]));
    case (mode_q)
      MODE_CURVE: begin
        for (int c = 0; c < 3; c++) pix_d[c] = sat_pix(curve_sum[c]);
      end
      MODE_SEPIA: begin
        pix_d[0] = sat_pix(sepia_red);
        pix_d[1] = sat_pix($signed(SUM_W'(s3_quo_q[3])));
        pix_d[2] = sat_pix($signed(SUM_W'(s3_quo_q[4])));
      end
      default: begin
        pix_d = s3_pix_q;  // bypass and unused mode code
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      pix_q   <= pix_d;
      alpha_q <= s3_alpha_q;
      fe_q    <= s3_fe_q;
    end
  end

  assign red_out_o       = pix_q[0];
  assign green_out_o     = pix_q[1];
  assign blue_out_o      = pix_q[2];
  assign alpha_out_o     = alpha_q;
  assign frame_end_out_o = fe_q;

endmodule
